### rtl/ibcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// ibcs_pkg
// Shared types and constants for the imu bias calibrate and smooth unit.
// ------------------------------------------------------------------------
package ibcs_pkg;

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned LIMIT_W     = 32;
    localparam int unsigned ALPHA_W     = 17;
    localparam int unsigned TARGET_W    = 10;
    localparam int unsigned ALPHA_SHIFT = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SQ_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SQ_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SQ_MAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION_TARGET = 3'd4;

    localparam logic [LIMIT_W-1:0]  RST_ACCEL_SQ_MIN = 32'd10737418;
    localparam logic [LIMIT_W-1:0]  RST_ACCEL_SQ_MAX = 32'd24159191;
    localparam logic [LIMIT_W-1:0]  RST_GYRO_SQ_MAX  = 32'd102400;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA        = 17'd13107;
    localparam logic [TARGET_W-1:0] RST_TARGET       = 10'd100;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE        = 17'd65536;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SQ     = 10'b0000000010,
        ST_NORM   = 10'b0000000100,
        ST_DECIDE = 10'b0000001000,
        ST_DIVLD  = 10'b0000010000,
        ST_DIV    = 10'b0000100000,
        ST_BIAS   = 10'b0001000000,
        ST_MUL    = 10'b0010000000,
        ST_UPD    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic seed;
        logic clear;
        logic accum;
        logic div_load;
        logic div_step;
        logic bias_wr;
        logic mul;
        logic upd;
    } lane_ctrl_t;

endpackage
`default_nettype wire

### rtl/imu_bias_calibrate_and_smooth_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// imu_bias_calibrate_and_smooth_unit
// Gyro bias calibration by stillness detection and per-axis moving average.
//
// channel  dir  handshake            payload
// s_       in   s_valid / s_ready    s_accel_x/y/z, s_rate_x/y/z
// m_       out  m_valid / m_ready    m_smooth_accel_x/y/z, m_smooth_rate_x/y/z,
//                                    m_is_calibrated
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item at a time: an accepted item passes SQ, NORM, DECIDE, MUL, UPD
// and OUT before its result is valid; a still sample that updates the bias
// also passes DIVLD, DIV and BIAS, the bit-serial divider in each lane
// three lanes run in parallel; norms and calibration control merge them
// a held result does not block the next accept; it blocks only the end
// of the following item. synchronous active-low reset, no clearing pass
// ------------------------------------------------------------------------
module imu_bias_calibrate_and_smooth_unit #(
    parameter int unsigned SAMPLE_BITS       = 16,
    parameter int unsigned AVERAGE_FRAC_BITS = 16,
    parameter int unsigned COUNT_BITS        = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_accel_z,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_rate_x,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_rate_y,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_rate_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]            m_smooth_accel_x,
    output logic signed [SAMPLE_BITS-1:0]            m_smooth_accel_y,
    output logic signed [SAMPLE_BITS-1:0]            m_smooth_accel_z,
    output logic signed [SAMPLE_BITS-1:0]            m_smooth_rate_x,
    output logic signed [SAMPLE_BITS-1:0]            m_smooth_rate_y,
    output logic signed [SAMPLE_BITS-1:0]            m_smooth_rate_z,
    output logic                                     m_is_calibrated,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ibcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ibcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ibcs_pkg::*;

    localparam int unsigned S         = SAMPLE_BITS;
    localparam int unsigned CB        = COUNT_BITS;
    localparam int unsigned SQ_W      = 2 * S;
    localparam int unsigned NW        = (SQ_W + 2 > LIMIT_W) ? SQ_W + 2 : LIMIT_W;
    localparam int unsigned TW        = (CB > TARGET_W) ? CB : TARGET_W;
    localparam int unsigned DIV_STEPS = S + CB;
    localparam int unsigned DC_W      = $clog2(DIV_STEPS + 1);

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   accel_min_reg, accel_max_reg, gyro_max_reg;
    logic [ALPHA_W-1:0]   alpha_reg, alpha_eff;
    logic [TARGET_W-1:0]  target_reg;
    logic                 seeded_reg, cal_reg;
    logic [CB-1:0]        count_reg, count_after;
    logic [DC_W-1:0]      div_cnt_reg;
    logic [NW-1:0]        asq_reg, gsq_reg;
    logic                 still, count_full;
    lane_ctrl_t           ctrl;

    logic signed [S-1:0]  lane_acc_in [3];
    logic signed [S-1:0]  lane_rate_in [3];
    logic [SQ_W-1:0]      lane_acc_sq [3];
    logic [SQ_W-1:0]      lane_rate_sq [3];
    logic signed [S-1:0]  lane_sm_acc [3];
    logic signed [S-1:0]  lane_sm_rate [3];

    assign lane_acc_in[0]  = s_accel_x;
    assign lane_acc_in[1]  = s_accel_y;
    assign lane_acc_in[2]  = s_accel_z;
    assign lane_rate_in[0] = s_rate_x;
    assign lane_rate_in[1] = s_rate_y;
    assign lane_rate_in[2] = s_rate_z;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ibcs_lane #(
            .SAMPLE_BITS      (SAMPLE_BITS),
            .AVERAGE_FRAC_BITS(AVERAGE_FRAC_BITS),
            .COUNT_BITS       (COUNT_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .accel_in    (lane_acc_in[g]),
            .rate_in     (lane_rate_in[g]),
            .alpha       (alpha_eff),
            .divisor     (count_reg),
            .accel_sq    (lane_acc_sq[g]),
            .rate_sq     (lane_rate_sq[g]),
            .smooth_accel(lane_sm_acc[g]),
            .smooth_rate (lane_sm_rate[g])
        );
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign still = (asq_reg > NW'(accel_min_reg)) && (asq_reg < NW'(accel_max_reg))
                && (gsq_reg < NW'(gyro_max_reg));
    assign count_full  = (count_reg == {CB{1'b1}});
    assign count_after = count_full ? count_reg : count_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.load     = s_valid && s_ready;
        ctrl.square   = (state_reg == ST_SQ);
        ctrl.div_load = (state_reg == ST_DIVLD);
        ctrl.div_step = (state_reg == ST_DIV);
        ctrl.bias_wr  = (state_reg == ST_BIAS);
        ctrl.mul      = (state_reg == ST_MUL);
        ctrl.upd      = (state_reg == ST_UPD);
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SQ;
            ST_SQ:     state_next = ST_NORM;
            ST_NORM:   state_next = ST_DECIDE;
            ST_DECIDE: begin
                ctrl.seed  = !seeded_reg;
                ctrl.accum = !cal_reg && still && !count_full;
                ctrl.clear = !cal_reg && !still;
                state_next = (!cal_reg && still && !count_full) ? ST_DIVLD : ST_MUL;
            end
            ST_DIVLD:  state_next = ST_DIV;
            ST_DIV:    if (div_cnt_reg == DC_W'(DIV_STEPS - 1)) state_next = ST_BIAS;
            ST_BIAS:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_UPD;
            ST_UPD:    state_next = ST_OUT;
            ST_OUT:    if (!m_valid || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_NORM) begin
            asq_reg <= NW'(lane_acc_sq[0]) + NW'(lane_acc_sq[1]) + NW'(lane_acc_sq[2]);
            gsq_reg <= NW'(lane_rate_sq[0]) + NW'(lane_rate_sq[1]) + NW'(lane_rate_sq[2]);
        end
        if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
            m_smooth_accel_x <= lane_sm_acc[0];
            m_smooth_accel_y <= lane_sm_acc[1];
            m_smooth_accel_z <= lane_sm_acc[2];
            m_smooth_rate_x  <= lane_sm_rate[0];
            m_smooth_rate_y  <= lane_sm_rate[1];
            m_smooth_rate_z  <= lane_sm_rate[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            accel_min_reg   <= RST_ACCEL_SQ_MIN;
            accel_max_reg   <= RST_ACCEL_SQ_MAX;
            gyro_max_reg    <= RST_GYRO_SQ_MAX;
            alpha_reg       <= RST_ALPHA;
            target_reg      <= RST_TARGET;
            seeded_reg      <= 1'b0;
            cal_reg         <= 1'b0;
            count_reg       <= '0;
            div_cnt_reg     <= '0;
            m_valid         <= 1'b0;
            m_is_calibrated <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ACCEL_SQ_MIN:       accel_min_reg <= cfg_data;
                    CFG_ACCEL_SQ_MAX:       accel_max_reg <= cfg_data;
                    CFG_GYRO_SQ_MAX:        gyro_max_reg  <= cfg_data;
                    CFG_SMOOTHING_ALPHA:    alpha_reg     <= cfg_data[ALPHA_W-1:0];
                    CFG_CALIBRATION_TARGET: target_reg    <= cfg_data[TARGET_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DECIDE) begin
                seeded_reg <= 1'b1;
                if (!cal_reg) begin
                    if (still) begin
                        count_reg <= count_after;
                        if (TW'(count_after) >= TW'(target_reg)) cal_reg <= 1'b1;
                    end else begin
                        count_reg <= '0;
                    end
                end
            end
            if (state_reg == ST_DIVLD) div_cnt_reg <= '0;
            else if (state_reg == ST_DIV) div_cnt_reg <= div_cnt_reg + 1'b1;
            if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
                m_valid         <= 1'b1;
                m_is_calibrated <= cal_reg;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ibcs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// ibcs_lane
// One axis: squares, rate sum, serial bias divider and both moving averages.
// ------------------------------------------------------------------------
module ibcs_lane #(
    parameter int unsigned SAMPLE_BITS       = 16,
    parameter int unsigned AVERAGE_FRAC_BITS = 16,
    parameter int unsigned COUNT_BITS        = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ibcs_pkg::lane_ctrl_t                ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]       accel_in,
    input  wire logic signed [SAMPLE_BITS-1:0]       rate_in,
    input  wire logic [ibcs_pkg::ALPHA_W-1:0]        alpha,
    input  wire logic [COUNT_BITS-1:0]               divisor,
    output logic [2*SAMPLE_BITS-1:0]                 accel_sq,
    output logic [2*SAMPLE_BITS-1:0]                 rate_sq,
    output logic signed [SAMPLE_BITS-1:0]            smooth_accel,
    output logic signed [SAMPLE_BITS-1:0]            smooth_rate
);
    import ibcs_pkg::*;

    localparam int unsigned S      = SAMPLE_BITS;
    localparam int unsigned F      = AVERAGE_FRAC_BITS;
    localparam int unsigned CB     = COUNT_BITS;
    localparam int unsigned AVG_W  = S + F;
    localparam int unsigned SUM_W  = S + CB;
    localparam int unsigned PROD_W = AVG_W + 1 + ALPHA_W + 1;

    logic signed [S-1:0]      acc_reg, rate_reg, bias_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [CB:0]              rem_reg;
    logic                     neg_reg;
    logic signed [AVG_W-1:0]  acc_avg_reg, rate_avg_reg;
    logic signed [PROD_W-1:0] acc_prod_reg, rate_prod_reg;
    logic [2*S-1:0]           acc_sq_reg, rate_sq_reg;

    logic signed [2*S-1:0]    acc_sq_s, rate_sq_s;
    logic [CB:0]              rem_sh, rem_next;
    logic                     rem_ge;
    logic [SUM_W-1:0]         quo_next, sum_mag, quo_s;
    logic signed [S:0]        diff;
    logic signed [S-1:0]      corr;
    logic signed [AVG_W:0]    d_acc, d_rate;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [PROD_W-1:0] acc_adj, rate_adj, acc_step, rate_step;
    logic signed [AVG_W-1:0]  acc_out_adj, rate_out_adj;

    assign acc_sq_s  = acc_reg * acc_reg;
    assign rate_sq_s = rate_reg * rate_reg;

    // restoring divide of |sum| by the still count, one quotient bit a cycle
    assign rem_sh   = {rem_reg[CB-1:0], quo_reg[SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, divisor};
    assign rem_next = rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
    assign quo_next = {quo_reg[SUM_W-2:0], rem_ge};
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quo_s    = neg_reg ? -quo_reg : quo_reg;

    // rate minus bias, saturated
    assign diff = {rate_reg[S-1], rate_reg} - {bias_reg[S-1], bias_reg};
    assign corr = (diff[S] ^ diff[S-1]) ? {diff[S], {(S-1){~diff[S]}}} : diff[S-1:0];

    assign d_acc   = {acc_reg[S-1], acc_reg, {F{1'b0}}} - {acc_avg_reg[AVG_W-1], acc_avg_reg};
    assign d_rate  = {corr[S-1], corr, {F{1'b0}}} - {rate_avg_reg[AVG_W-1], rate_avg_reg};
    assign alpha_s = {1'b0, alpha};

    // divide by 2^16 toward zero
    assign acc_adj   = acc_prod_reg
                     + {{(PROD_W-ALPHA_SHIFT){1'b0}}, {ALPHA_SHIFT{acc_prod_reg[PROD_W-1]}}};
    assign rate_adj  = rate_prod_reg
                     + {{(PROD_W-ALPHA_SHIFT){1'b0}}, {ALPHA_SHIFT{rate_prod_reg[PROD_W-1]}}};
    assign acc_step  = acc_adj >>> ALPHA_SHIFT;
    assign rate_step = rate_adj >>> ALPHA_SHIFT;

    assign acc_out_adj  = acc_avg_reg + {{(AVG_W-F){1'b0}}, {F{acc_avg_reg[AVG_W-1]}}};
    assign rate_out_adj = rate_avg_reg + {{(AVG_W-F){1'b0}}, {F{rate_avg_reg[AVG_W-1]}}};
    assign smooth_accel = acc_out_adj[AVG_W-1:F];
    assign smooth_rate  = rate_out_adj[AVG_W-1:F];
    assign accel_sq     = acc_sq_reg;
    assign rate_sq      = rate_sq_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg  <= accel_in;
            rate_reg <= rate_in;
        end
        if (ctrl.square) begin
            acc_sq_reg  <= acc_sq_s;
            rate_sq_reg <= rate_sq_s;
        end
        if (ctrl.div_load) begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_mag;
            rem_reg <= '0;
        end else if (ctrl.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctrl.mul) begin
            acc_prod_reg  <= d_acc * alpha_s;
            rate_prod_reg <= d_rate * alpha_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            bias_reg     <= '0;
            acc_avg_reg  <= '0;
            rate_avg_reg <= '0;
        end else begin
            if (ctrl.clear) begin
                sum_reg  <= '0;
                bias_reg <= '0;
            end else if (ctrl.accum) begin
                sum_reg <= sum_reg + SUM_W'(rate_reg);
            end
            if (ctrl.bias_wr) begin
                bias_reg <= quo_s[S-1:0];
            end
            if (ctrl.seed) begin
                acc_avg_reg <= {acc_reg, {F{1'b0}}};
            end else if (ctrl.upd) begin
                acc_avg_reg <= acc_avg_reg + acc_step[AVG_W-1:0];
            end
            if (ctrl.upd) begin
                rate_avg_reg <= rate_avg_reg + rate_step[AVG_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ibcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// ibcs_checker
// Port-level checks for the imu bias calibrate and smooth unit.
// ------------------------------------------------------------------------
module ibcs_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_is_calibrated,
    input wire logic cfg_ready
);

    // a held result stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    // calibration never undoes itself
    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(m_is_calibrated))
        else $error("calibrated flag dropped");

    // register writes are never stalled
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port stalled");

endmodule

bind imu_bias_calibrate_and_smooth_unit ibcs_checker u_ibcs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_is_calibrated(m_is_calibrated),
    .cfg_ready      (cfg_ready)
);
`default_nettype wire
